[design/assert_macros.svh]
// Assertion macros used by the checker module.
// Depends on clk and rst_n ports of the module that includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_IMPLY(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

[design/bbrf_pkg.sv]
// Package for the byte-budget record FIFO: sizes, reset values, codes and
// the command/status structs between controller and datapath. No dependencies.
package bbrf_pkg;

  localparam int BBRF_DEPTH         = 64;
  localparam int BBRF_PAYLOAD_WIDTH = 64;

  localparam int DATA_W     = 64;
  localparam int SIZE_W     = 32;
  localparam int REC_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [REC_W-1:0]  RECORD_LIMIT_RST  = 7'd64;
  localparam logic [SIZE_W-1:0] BYTE_LIMIT_RST    = 32'd65536;
  localparam logic              OVERFLOW_MODE_RST = 1'b1;

  typedef enum logic [1:0] {
    KIND_PUBLISH = 2'd0,
    KIND_POP     = 2'd1,
    KIND_CLOSE   = 2'd2,
    KIND_STATUS  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RECORD_LIMIT  = 2'd0,
    CFG_BYTE_LIMIT    = 2'd1,
    CFG_OVERFLOW_MODE = 2'd2
  } cfg_idx_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;  // latch the incoming item
    logic evict;    // drop the oldest record, stay on this item
    logic finish;   // apply the item and present its result
  } ctl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic evict_needed;
  } dp_status_t;

endpackage

[design/bbrf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/bbrf_ctrl.sv]
// Controller for the byte-budget record FIFO: accept, evict loop, finish.
// Depends on bbrf_pkg.
module bbrf_ctrl import bbrf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t status,
  output ctl_cmd_t   cmd,
  output logic       busy
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    busy        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        busy = 1'b1;
        if (status.evict_needed) begin
          cmd.evict = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/bbrf_dpath.sv]
// Datapath for the byte-budget record FIFO: config registers, ring pointers,
// counters, entry RAM and result registers. Depends on bbrf_pkg, bbrf_ram.
module bbrf_dpath import bbrf_pkg::*; #(
  parameter int DEPTH         = BBRF_DEPTH,
  parameter int PAYLOAD_WIDTH = BBRF_PAYLOAD_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [1:0]            in_kind,
  input  logic [DATA_W-1:0]     in_record_data,
  input  logic [SIZE_W-1:0]     in_record_bytes,
  input  ctl_cmd_t              cmd,
  output dp_status_t            status,
  output logic                  out_valid,
  output logic                  out_publish_accepted,
  output logic [REC_W-1:0]      out_evicted_now,
  output logic                  out_pop_valid,
  output logic [DATA_W-1:0]     out_pop_data,
  output logic [SIZE_W-1:0]     out_pop_bytes,
  output logic [REC_W-1:0]      out_held_records,
  output logic [SIZE_W-1:0]     out_held_bytes,
  output logic [DATA_W-1:0]     out_dropped_total,
  output logic                  out_is_closed
);

  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int LIM_W   = (CNT_W > REC_W) ? CNT_W : REC_W;
  localparam int ENTRY_W = PAYLOAD_WIDTH + SIZE_W;

  // configuration
  logic [REC_W-1:0]  record_limit_r;
  logic [SIZE_W-1:0] byte_limit_r;
  logic              overflow_mode_r;

  // captured item
  kind_t                    kind_r;
  logic [PAYLOAD_WIDTH-1:0] data_r;
  logic [SIZE_W-1:0]        bytes_r;

  // queue state
  logic [PTR_W-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SIZE_W-1:0] total_r, total_nxt;
  logic [DATA_W-1:0] drop_r, drop_nxt;
  logic              closed_r, closed_nxt;
  logic [REC_W-1:0]  evict_r, evict_nxt;

  // result registers
  logic                     valid_r;
  logic                     acc_r, acc_nxt;
  logic                     pop_valid_r, pop_hit;
  logic [PAYLOAD_WIDTH-1:0] pop_data_r;
  logic [SIZE_W-1:0]        pop_bytes_r;

  logic [ENTRY_W-1:0]       rd_entry;
  logic [SIZE_W-1:0]        rd_size;
  logic [PAYLOAD_WIDTH-1:0] rd_payload;
  logic                     ram_we;

  logic [LIM_W-1:0] lim_ext, eff_lim;
  logic             over_budget, drop_pub;
  logic [PTR_W-1:0] head_inc, tail_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_limit_r  <= RECORD_LIMIT_RST;
      byte_limit_r    <= BYTE_LIMIT_RST;
      overflow_mode_r <= OVERFLOW_MODE_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RECORD_LIMIT:  record_limit_r  <= cfg_wdata[REC_W-1:0];
        CFG_BYTE_LIMIT:    byte_limit_r    <= cfg_wdata[SIZE_W-1:0];
        CFG_OVERFLOW_MODE: overflow_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= kind_t'(in_kind);
      data_r  <= in_record_data[PAYLOAD_WIDTH-1:0];
      bytes_r <= in_record_bytes;
    end
  end

  // Clamp the record limit to 1..DEPTH.
  assign lim_ext = LIM_W'(record_limit_r);
  assign eff_lim = (record_limit_r == '0)      ? LIM_W'(1) :
                   (lim_ext > LIM_W'(DEPTH))   ? LIM_W'(DEPTH) : lim_ext;

  assign over_budget = (LIM_W'(count_r) >= eff_lim) ||
                       (({1'b0, total_r} + {1'b0, bytes_r}) > {1'b0, byte_limit_r});
  assign drop_pub = closed_r || (bytes_r > byte_limit_r) ||
                    (!overflow_mode_r && over_budget);

  assign status.evict_needed = (kind_r == KIND_PUBLISH) && !drop_pub &&
                               (count_r != '0) && over_budget;

  assign head_inc = (head_r == PTR_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == PTR_W'(DEPTH - 1)) ? '0 : tail_r + 1'b1;

  assign rd_size    = rd_entry[SIZE_W-1:0];
  assign rd_payload = rd_entry[ENTRY_W-1:SIZE_W];

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    total_nxt  = total_r;
    drop_nxt   = drop_r;
    closed_nxt = closed_r;
    evict_nxt  = evict_r;
    acc_nxt    = 1'b0;
    pop_hit    = 1'b0;
    ram_we     = 1'b0;
    if (cmd.capture) begin
      evict_nxt = '0;
    end
    if (cmd.evict) begin
      head_nxt  = head_inc;
      count_nxt = count_r - 1'b1;
      total_nxt = total_r - rd_size;
      drop_nxt  = drop_r + 1'b1;
      evict_nxt = evict_r + 1'b1;
    end
    if (cmd.finish) begin
      case (kind_r)
        KIND_PUBLISH: begin
          if (drop_pub) begin
            drop_nxt = drop_r + 1'b1;
          end else begin
            ram_we    = 1'b1;
            tail_nxt  = tail_inc;
            count_nxt = count_r + 1'b1;
            total_nxt = total_r + bytes_r;
            acc_nxt   = 1'b1;
          end
        end
        KIND_POP: begin
          if (count_r != '0) begin
            pop_hit   = 1'b1;
            head_nxt  = head_inc;
            count_nxt = count_r - 1'b1;
            total_nxt = total_r - rd_size;
          end
        end
        KIND_CLOSE: begin
          closed_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      total_r  <= '0;
      drop_r   <= '0;
      closed_r <= 1'b0;
      evict_r  <= '0;
      valid_r  <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      total_r  <= total_nxt;
      drop_r   <= drop_nxt;
      closed_r <= closed_nxt;
      evict_r  <= evict_nxt;
      valid_r  <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      acc_r       <= acc_nxt;
      pop_valid_r <= pop_hit;
      pop_data_r  <= pop_hit ? rd_payload : '0;
      pop_bytes_r <= pop_hit ? rd_size : '0;
    end
  end

  // Read address follows the next head, so an evict or pop reads the head entry.
  bbrf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata ({data_r, bytes_r}),
    .raddr (head_nxt),
    .rdata (rd_entry)
  );

  assign out_valid            = valid_r;
  assign out_publish_accepted = acc_r;
  assign out_evicted_now      = evict_r;
  assign out_pop_valid        = pop_valid_r;
  assign out_pop_data         = DATA_W'(pop_data_r);
  assign out_pop_bytes        = pop_bytes_r;
  assign out_held_records     = REC_W'(count_r);
  assign out_held_bytes       = total_r;
  assign out_dropped_total    = drop_r;
  assign out_is_closed        = closed_r;

endmodule

[design/byte_budget_record_fifo_core.sv]
// Top level of the byte-budget record FIFO: controller plus datapath.
// Depends on bbrf_pkg, bbrf_ctrl, bbrf_dpath (and bbrf_ram below it).
//
// Usage:
//   Command channel: drive in_kind / in_record_data / in_record_bytes with start;
//   the item is taken at a clock edge where start is high and busy is low.
//   Kinds: publish, pop oldest, close, status only.
//   Result channel: out_valid is high for exactly one cycle per item, with all
//   out_ fields valid in that cycle; the receiver cannot stall it.
//   Config port: cfg_we / cfg_index / cfg_wdata write record_limit, byte_limit
//   and overflow_mode; write only while no item is in flight.
//   Sequence: an item is accepted, then evaluated; a drop-oldest publish first
//   evicts the records it needs to, and the eviction loop reads one head entry
//   per cycle from the single read port of the entry RAM. The result strobe
//   comes in the cycle after evaluation ends, when busy is already low, so a
//   new item can be taken in that same cycle.
//   Reset: synchronous, active low; empties the queue, clears the drop count
//   and closed flag, loads config defaults. No clearing pass is needed.
module byte_budget_record_fifo_core import bbrf_pkg::*; #(
  parameter int DEPTH         = BBRF_DEPTH,
  parameter int PAYLOAD_WIDTH = BBRF_PAYLOAD_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_kind,
  input  logic [DATA_W-1:0]     in_record_data,
  input  logic [SIZE_W-1:0]     in_record_bytes,
  output logic                  out_valid,
  output logic                  out_publish_accepted,
  output logic [REC_W-1:0]      out_evicted_now,
  output logic                  out_pop_valid,
  output logic [DATA_W-1:0]     out_pop_data,
  output logic [SIZE_W-1:0]     out_pop_bytes,
  output logic [REC_W-1:0]      out_held_records,
  output logic [SIZE_W-1:0]     out_held_bytes,
  output logic [DATA_W-1:0]     out_dropped_total,
  output logic                  out_is_closed
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  // Sequence each item: capture, evict as long as needed, then finish.
  bbrf_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Hold the queue, the limits and the result fields.
  bbrf_dpath #(
    .DEPTH         (DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_kind              (in_kind),
    .in_record_data       (in_record_data),
    .in_record_bytes      (in_record_bytes),
    .cmd                  (cmd),
    .status               (status),
    .out_valid            (out_valid),
    .out_publish_accepted (out_publish_accepted),
    .out_evicted_now      (out_evicted_now),
    .out_pop_valid        (out_pop_valid),
    .out_pop_data         (out_pop_data),
    .out_pop_bytes        (out_pop_bytes),
    .out_held_records     (out_held_records),
    .out_held_bytes       (out_held_bytes),
    .out_dropped_total    (out_dropped_total),
    .out_is_closed        (out_is_closed)
  );

endmodule

[design/bbrf_checker.sv]
// Port-level checker for the byte-budget record FIFO, with its bind.
// Depends on bbrf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bbrf_checker import bbrf_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic             out_publish_accepted,
  input logic [REC_W-1:0] out_evicted_now,
  input logic             out_pop_valid
);

  `CHK_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `CHK_IMPLY(a_result_after_busy, out_valid, $past(busy), "result without work")
  `CHK_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe longer than one cycle")
  `CHK_IMPLY(a_evict_only_on_store, out_valid && (out_evicted_now != '0), out_publish_accepted, "eviction on a publish that was not stored")
  `CHK_IMPLY(a_pop_not_publish, out_valid && out_pop_valid, !out_publish_accepted, "pop and publish in one result")

endmodule

bind byte_budget_record_fifo_core bbrf_checker u_bbrf_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .out_valid            (out_valid),
  .out_publish_accepted (out_publish_accepted),
  .out_evicted_now      (out_evicted_now),
  .out_pop_valid        (out_pop_valid)
);

[sim/byte_budget_record_fifo_core_tb.sv]
// Self-checking testbench for byte_budget_record_fifo_core: drives publish, pop, close
// and status items, tracks queue contents in a scoreboard class and checks every result.
// Depends on bbrf_pkg and the byte_budget_record_fifo_core RTL.
import bbrf_pkg::*;

typedef struct packed {
  logic               publish_accepted;
  logic [REC_W-1:0]   evicted_now;
  logic               pop_valid;
  logic [DATA_W-1:0]  pop_data;
  logic [SIZE_W-1:0]  pop_bytes;
  logic [REC_W-1:0]   held_records;
  logic [SIZE_W-1:0]  held_bytes;
  logic [DATA_W-1:0]  dropped_total;
  logic               is_closed;
} fifo_result_t;

class record_fifo_scoreboard;
  // Shadow copy of the queue and its limits
  logic [DATA_W-1:0] slot_data [BBRF_DEPTH];
  logic [SIZE_W-1:0] slot_size [BBRF_DEPTH];
  int                head;
  int                tail;
  int                count;
  logic [SIZE_W-1:0] byte_sum;
  logic [DATA_W-1:0] drops;
  logic              closed;
  logic [REC_W-1:0]  rec_lim;
  logic [SIZE_W-1:0] byte_lim;
  logic              evict_mode;
  fifo_result_t      due_results[$];
  int                mismatches;

  function new();
    head       = 0;
    tail       = 0;
    count      = 0;
    byte_sum   = '0;
    drops      = '0;
    closed     = 1'b0;
    rec_lim    = RECORD_LIMIT_RST;
    byte_lim   = BYTE_LIMIT_RST;
    evict_mode = OVERFLOW_MODE_RST;
    mismatches = 0;
  endfunction

  function void set_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_RECORD_LIMIT:  rec_lim = v[REC_W-1:0];
      CFG_BYTE_LIMIT:    byte_lim = v[SIZE_W-1:0];
      CFG_OVERFLOW_MODE: evict_mode = v[0];
      default: ;
    endcase
  endfunction

  // Zero behaves as one, anything above the depth as the depth
  function int record_cap();
    if (rec_lim == 0) return 1;
    if (rec_lim > BBRF_DEPTH) return BBRF_DEPTH;
    return rec_lim;
  endfunction

  function bit no_room(logic [SIZE_W-1:0] rb);
    return count >= record_cap() || (33'(byte_sum) + 33'(rb)) > 33'(byte_lim);
  endfunction

  function void drop_head();
    byte_sum = byte_sum - slot_size[head];
    head = (head + 1) % BBRF_DEPTH;
    count--;
  endfunction

  function int outstanding();
    return due_results.size();
  endfunction

  // Apply one accepted item to the shadow queue and queue up its result
  function void predict_item(kind_t k, logic [DATA_W-1:0] d, logic [SIZE_W-1:0] rb);
    fifo_result_t r;
    r = '0;
    case (k)
      KIND_PUBLISH: begin
        if (closed || rb > byte_lim || (!evict_mode && no_room(rb))) begin
          drops++;
        end else begin
          while (count > 0 && no_room(rb)) begin
            drop_head();
            drops++;
            r.evicted_now++;
          end
          slot_data[tail] = d;
          slot_size[tail] = rb;
          tail = (tail + 1) % BBRF_DEPTH;
          count++;
          byte_sum = byte_sum + rb;
          r.publish_accepted = 1'b1;
        end
      end
      KIND_POP: begin
        if (count > 0) begin
          r.pop_valid = 1'b1;
          r.pop_data  = slot_data[head];
          r.pop_bytes = slot_size[head];
          drop_head();
        end
      end
      KIND_CLOSE: closed = 1'b1;
      default: ;
    endcase
    r.held_records  = count[REC_W-1:0];
    r.held_bytes    = byte_sum;
    r.dropped_total = drops;
    r.is_closed     = closed;
    due_results.insert(due_results.size(), r);
  endfunction

  function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
    end
  endfunction

  function void check_result(fifo_result_t got);
    fifo_result_t want;
    if (due_results.size() == 0) begin
      mismatches++;
      $error("result arrived with no item waiting for it");
      return;
    end
    want = due_results[0];
    due_results.delete(0);
    cmp_field("publish_accepted", want.publish_accepted, got.publish_accepted);
    cmp_field("evicted_now", want.evicted_now, got.evicted_now);
    cmp_field("pop_valid", want.pop_valid, got.pop_valid);
    cmp_field("pop_data", want.pop_data, got.pop_data);
    cmp_field("pop_bytes", want.pop_bytes, got.pop_bytes);
    cmp_field("held_records", want.held_records, got.held_records);
    cmp_field("held_bytes", want.held_bytes, got.held_bytes);
    cmp_field("dropped_total", want.dropped_total, got.dropped_total);
    cmp_field("is_closed", want.is_closed, got.is_closed);
  endfunction
endclass

module byte_budget_record_fifo_core_tb;

  // Slowest legal run: ~1900 items, each with the longest eviction loop and the
  // longest gap; the limit allows about four times that run.
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TARGET_ITEMS = 1900;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_RECORD_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            in_kind = KIND_STATUS;
  logic [DATA_W-1:0]     in_record_data = '0;
  logic [SIZE_W-1:0]     in_record_bytes = '0;
  logic                  out_valid;
  logic                  out_publish_accepted;
  logic [REC_W-1:0]      out_evicted_now;
  logic                  out_pop_valid;
  logic [DATA_W-1:0]     out_pop_data;
  logic [SIZE_W-1:0]     out_pop_bytes;
  logic [REC_W-1:0]      out_held_records;
  logic [SIZE_W-1:0]     out_held_bytes;
  logic [DATA_W-1:0]     out_dropped_total;
  logic                  out_is_closed;

  record_fifo_scoreboard sb = new();
  int  item_count = 0;
  bit  dense_run = 1'b0;

  byte_budget_record_fifo_core u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .start                (start),
    .busy                 (busy),
    .in_kind              (in_kind),
    .in_record_data       (in_record_data),
    .in_record_bytes      (in_record_bytes),
    .out_valid            (out_valid),
    .out_publish_accepted (out_publish_accepted),
    .out_evicted_now      (out_evicted_now),
    .out_pop_valid        (out_pop_valid),
    .out_pop_data         (out_pop_data),
    .out_pop_bytes        (out_pop_bytes),
    .out_held_records     (out_held_records),
    .out_held_bytes       (out_held_bytes),
    .out_dropped_total    (out_dropped_total),
    .out_is_closed        (out_is_closed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Sample both channels at the clock edge. Check the result first: it always
  // belongs to an older item than one taken at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        sb.check_result('{out_publish_accepted, out_evicted_now, out_pop_valid,
                          out_pop_data, out_pop_bytes, out_held_records,
                          out_held_bytes, out_dropped_total, out_is_closed});
      end
      if (start && !busy) begin
        sb.predict_item(kind_t'(in_kind), in_record_data, in_record_bytes);
      end
    end
  end

  // Watchdog: end the run if the block hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("byte_budget_record_fifo_core_tb: done, errors");
    $finish;
  end

  // Mostly short gaps, a few long ones; none at all during a dense run
  function automatic int rand_gap();
    int r;
    if (dense_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 6) return '1;
    return {$urandom, $urandom};
  endfunction

  // Byte sizes around the current budget: zero, all ones, exact fit, one over,
  // full-range random, and a share of the budget so several records fit
  function automatic logic [SIZE_W-1:0] pick_bytes();
    int r;
    logic [SIZE_W-1:0] lim;
    logic [SIZE_W-1:0] part;
    lim = sb.byte_lim;
    r = $urandom_range(0, 99);
    part = lim / $urandom_range(2, 12);
    if (part == 0) part = 1;
    if (r < 2) return '0;
    if (r < 5) return '1;
    if (r < 9) return lim;
    if (r < 12) return lim + 1;
    if (r < 16) return $urandom;
    return $urandom_range(1, part);
  endfunction

  function automatic logic [REC_W-1:0] pick_rec_limit();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return 7'd1;
    if (r == 2) return '1;
    if (r == 3) return 7'd64;
    if (r < 7) return REC_W'($urandom_range(2, 8));
    return REC_W'($urandom_range(1, 64));
  endfunction

  function automatic logic [SIZE_W-1:0] pick_byte_limit();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd1;
    if (r == 1) return '1;
    if (r == 2) return 32'd65536;
    if (r == 3) return $urandom;
    return $urandom_range(16, 3000);
  endfunction

  // Present one item, hold it until the block takes it, then idle a random gap
  task automatic drive_item(kind_t k, logic [DATA_W-1:0] d, logic [SIZE_W-1:0] b);
    int gap;
    gap = rand_gap();
    start           <= 1'b1;
    in_kind         <= k;
    in_record_data  <= d;
    in_record_bytes <= b;
    do @(posedge clk); while (busy);
    item_count++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and wait until every expected result has come back
  task automatic wait_drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0 || busy);
  endtask

  // Write all three registers while the block is idle
  task automatic set_limits(logic [REC_W-1:0] rl, logic [SIZE_W-1:0] bl, logic m);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RECORD_LIMIT;
    cfg_wdata <= CFG_DATA_W'(rl);
    @(posedge clk);
    cfg_index <= CFG_BYTE_LIMIT;
    cfg_wdata <= bl;
    @(posedge clk);
    cfg_index <= CFG_OVERFLOW_MODE;
    cfg_wdata <= CFG_DATA_W'(m);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.set_cfg(CFG_RECORD_LIMIT, CFG_DATA_W'(rl));
    sb.set_cfg(CFG_BYTE_LIMIT, bl);
    sb.set_cfg(CFG_OVERFLOW_MODE, CFG_DATA_W'(m));
  endtask

  initial begin
    int n;
    int r;
    int pop_w;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset limits: pop and status on an empty queue, zero-byte and
    // all-ones records, a record that fills the whole budget and evicts the rest,
    // records larger than the budget, pop until empty
    drive_item(KIND_POP, '0, '0);
    drive_item(KIND_STATUS, {$urandom, $urandom}, $urandom);
    drive_item(KIND_PUBLISH, '0, '0);
    drive_item(KIND_PUBLISH, '1, 32'd1);
    drive_item(KIND_PUBLISH, 64'hA5A5_5A5A_F00F_0FF0, 32'd65536);
    drive_item(KIND_PUBLISH, pick_data(), 32'd65537);
    drive_item(KIND_PUBLISH, pick_data(), '1);
    drive_item(KIND_POP, '0, '0);
    drive_item(KIND_POP, '0, '0);

    // Drop newest with a two-record cap and the widest byte budget
    set_limits(7'd2, '1, 1'b0);
    drive_item(KIND_PUBLISH, pick_data(), $urandom_range(1, 100));
    drive_item(KIND_PUBLISH, pick_data(), $urandom_range(1, 100));
    drive_item(KIND_PUBLISH, pick_data(), $urandom_range(1, 100));
    drive_item(KIND_POP, '0, '0);
    drive_item(KIND_PUBLISH, pick_data(), '1);
    drive_item(KIND_POP, '0, '0);
    drive_item(KIND_PUBLISH, pick_data(), '1);
    drive_item(KIND_STATUS, '0, '0);

    // A record limit of zero acts as one
    set_limits(7'd0, 32'd1000, 1'b1);
    drive_item(KIND_PUBLISH, pick_data(), 32'd10);
    drive_item(KIND_PUBLISH, pick_data(), 32'd20);
    drive_item(KIND_POP, '0, '0);

    // Fill to the depth with an oversized limit, then shrink the budget below
    // the contents so one publish evicts every held record
    set_limits('1, '1, 1'b1);
    repeat (70) drive_item(KIND_PUBLISH, pick_data(), $urandom_range(6, 1000));
    set_limits(7'd64, 32'd10, 1'b1);
    drive_item(KIND_PUBLISH, pick_data(), 32'd5);
    drive_item(KIND_POP, '0, '0);
    drive_item(KIND_POP, '0, '0);

    // Same in drop-newest mode: full queue drops, shrunken budget drops
    set_limits(7'd64, '1, 1'b0);
    repeat (65) drive_item(KIND_PUBLISH, pick_data(), $urandom_range(6, 1000));
    set_limits(7'd64, 32'd3, 1'b0);
    drive_item(KIND_PUBLISH, pick_data(), 32'd2);
    set_limits(7'd2, 32'd3, 1'b1);
    drive_item(KIND_PUBLISH, pick_data(), 32'd2);

    // Random phases, each with fresh limits and its own publish/pop mix. The
    // drain before every register write doubles as the sender pause.
    while (item_count < TARGET_ITEMS - 40) begin
      set_limits(pick_rec_limit(), pick_byte_limit(), 1'($urandom_range(0, 1)));
      n = $urandom_range(30, 150);
      dense_run = ($urandom_range(0, 4) == 0);
      pop_w = $urandom_range(15, 55);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 6)
          drive_item(KIND_STATUS, {$urandom, $urandom}, $urandom);
        else if (r < 6 + pop_w)
          drive_item(KIND_POP, {$urandom, $urandom}, $urandom);
        else
          drive_item(KIND_PUBLISH, pick_data(), pick_bytes());
      end
      dense_run = 1'b0;
    end

    // Close last since it cannot be undone: a second close changes nothing,
    // later publishes drop, pops still drain the queue down to empty
    set_limits(7'd8, 32'd4096, 1'b1);
    repeat (5) drive_item(KIND_PUBLISH, pick_data(), $urandom_range(1, 500));
    drive_item(KIND_CLOSE, {$urandom, $urandom}, $urandom);
    drive_item(KIND_CLOSE, '0, '0);
    drive_item(KIND_PUBLISH, pick_data(), 32'd1);
    drive_item(KIND_STATUS, '0, '0);
    while (sb.count > 0) drive_item(KIND_POP, '0, '0);
    drive_item(KIND_POP, '0, '0);
    drive_item(KIND_PUBLISH, pick_data(), pick_bytes());

    // Let the last result land, then watch a while longer for strays
    wait_drain();
    repeat (80) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("byte_budget_record_fifo_core_tb: done, clean");
    end else begin
      $display("byte_budget_record_fifo_core_tb: done, errors");
    end
    $finish;
  end

endmodule
